// File: rtl/core/bir_pkg.sv
// shared types, constants and helpers for the bilinear resize block
`default_nettype none

package bir_pkg;

    localparam int SIZE_W    = 8;
    localparam int COORD_W   = 7;
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int CHANNELS_DEF   = 3;

    // one row blend, the full two-row sum, and the divider operands
    localparam int HACC_W    = SAMPLE_W + SIZE_W;
    localparam int VACC_W    = SAMPLE_W + 2 * SIZE_W;
    localparam int DEN_W     = 2 * SIZE_W;
    localparam int POS_NUM_W = 2 * SIZE_W;
    localparam int DIV_NUM_W = VACC_W + 2;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W / 2 + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_DST_WIDTH,
        CFG_DST_HEIGHT
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVX,
        ST_DIVY,
        ST_RTL,
        ST_MTL,
        ST_MTR,
        ST_VT,
        ST_MBL,
        ST_MBR,
        ST_VB,
        ST_DIVO,
        ST_DIVW,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_OUT
    } div_sel_t;

    typedef enum logic [1:0] {
        TAP_TL,
        TAP_TR,
        TAP_BL,
        TAP_BR
    } tap_t;

    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_H_FIRST,
        MAC_H_ADD,
        MAC_V_FIRST,
        MAC_V_ADD
    } mac_op_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_x;
        logic     cap_y;
        logic     mem_rd;
        tap_t     tap;
        mac_op_t  mac_op;
        logic     load_out;
    } bir_cmd_t;

    typedef struct packed {
        logic in_read;
        logic bad;
        logic div_busy;
    } bir_status_t;

    // clamp a size register into 1..lim
    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned lim);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (32'(v) > lim) begin
            return SIZE_W'(lim);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bir_div.sv
// iterative restoring divider, two quotient bits per cycle
`default_nettype none

module bir_div
    import bir_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_CNT_W-1:0] steps,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]     den,
    output logic                      busy,
    output logic [DIV_NUM_W-1:0]      quo,
    output logic [DEN_W-1:0]          rem
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DIV_NUM_W-1:0] quo_next;
    logic [DEN_W-1:0]     rem_next;
    logic [DEN_W:0]       trial;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++) begin
            trial    = {rem_next, quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial       = trial - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= steps;
        end else if (busy) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bir_datapath.sv
// frame store, size registers, position divides, blend MACs and output register
`default_nettype none

module bir_datapath
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bir_cmd_t             cmd,
    output bir_status_t               st,
    input  wire logic                 s_mode,
    input  wire logic [CH_W-1:0]      s_channel,
    input  wire logic [COORD_W-1:0]   s_xpos,
    input  wire logic [COORD_W-1:0]   s_ypos,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    output logic [SAMPLE_W-1:0]       m_resized_sample,
    output logic                      m_status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    localparam int PLANE_WORDS = MAX_HEIGHT * MAX_WIDTH;
    localparam int FRAME_WORDS = CHANNELS * PLANE_WORDS;
    localparam int ADDR_W      = $clog2(FRAME_WORDS);

    logic [SIZE_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [SIZE_W-1:0] sw, sh, dw, dh, dw1, dh1;

    logic [CH_W-1:0]    ch_reg;
    logic [COORD_W-1:0] x_reg, y_reg;

    logic [SIZE_W-1:0] ix_reg, ixr_reg, rx_reg, iy_reg, iyb_reg, ry_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [HACC_W-1:0] hacc_reg;
    logic [VACC_W-1:0] vacc_reg;

    logic [SAMPLE_W-1:0] frame_mem [FRAME_WORDS];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_status_reg;

    logic              edge_col, edge_row, wr_ok, mem_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
    logic [SIZE_W-1:0] row_sel, col_sel;

    logic                 div_start, div_busy;
    logic [DIV_CNT_W-1:0] div_steps;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0]     div_den, div_rem;
    logic [POS_NUM_W-1:0] pos_num;

    logic [SIZE_W-1:0] h_wt, v_wt;
    logic [HACC_W-1:0] h_prod;
    logic [VACC_W-1:0] v_prod;

    // size registers, saturated before use
    assign sw  = sat_size(src_w_reg, MAX_WIDTH);
    assign sh  = sat_size(src_h_reg, MAX_HEIGHT);
    assign dw  = sat_size(dst_w_reg, MAX_WIDTH);
    assign dh  = sat_size(dst_h_reg, MAX_HEIGHT);
    assign dw1 = (dw > SIZE_W'(1)) ? dw - SIZE_W'(1) : SIZE_W'(1);
    assign dh1 = (dh > SIZE_W'(1)) ? dh - SIZE_W'(1) : SIZE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SIZE_W'(128);
            src_h_reg <= SIZE_W'(128);
            dst_w_reg <= SIZE_W'(128);
            dst_h_reg <= SIZE_W'(128);
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_SRC_WIDTH:  src_w_reg <= cfg_data;
                CFG_SRC_HEIGHT: src_h_reg <= cfg_data;
                CFG_DST_WIDTH:  dst_w_reg <= cfg_data;
                CFG_DST_HEIGHT: dst_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg <= s_channel;
            x_reg  <= s_xpos;
            y_reg  <= s_ypos;
        end
    end

    assign st.in_read  = s_mode;
    assign st.bad      = (32'(ch_reg) >= CHANNELS) || ({1'b0, x_reg} >= dw)
                         || ({1'b0, y_reg} >= dh);
    assign st.div_busy = div_busy;

    assign edge_col = ({1'b0, x_reg} == dw - SIZE_W'(1)) || (sw == SIZE_W'(1));
    assign edge_row = ({1'b0, y_reg} == dh - SIZE_W'(1)) || (sh == SIZE_W'(1));

    // frame store: single port, writes only while idle
    assign wr_ok = (32'(s_channel) < CHANNELS) && ({1'b0, s_xpos} < sw)
                   && ({1'b0, s_ypos} < sh);
    assign mem_we = cmd.accept && !s_mode && wr_ok;

    assign wr_addr = ADDR_W'(s_channel) * ADDR_W'(PLANE_WORDS)
                     + ADDR_W'(s_ypos) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s_xpos);

    assign row_sel = (cmd.tap == TAP_BL || cmd.tap == TAP_BR) ? iyb_reg : iy_reg;
    assign col_sel = (cmd.tap == TAP_TR || cmd.tap == TAP_BR) ? ixr_reg : ix_reg;
    assign rd_addr = ADDR_W'(ch_reg) * ADDR_W'(PLANE_WORDS)
                     + ADDR_W'(row_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);

    assign mem_addr = cmd.accept ? wr_addr : rd_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= s_sample;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= frame_mem[mem_addr];
        end
    end

    // divider operand select
    always_comb begin
        pos_num   = '0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        case (cmd.div_sel)
            DIV_X: begin
                pos_num   = POS_NUM_W'(x_reg) * POS_NUM_W'(sw - SIZE_W'(1));
                div_num   = {pos_num, {(DIV_NUM_W - POS_NUM_W){1'b0}}};
                div_den   = DEN_W'(dw1);
                div_steps = DIV_CNT_W'(POS_NUM_W / 2);
            end
            DIV_Y: begin
                pos_num   = POS_NUM_W'(y_reg) * POS_NUM_W'(sh - SIZE_W'(1));
                div_num   = {pos_num, {(DIV_NUM_W - POS_NUM_W){1'b0}}};
                div_den   = DEN_W'(dh1);
                div_steps = DIV_CNT_W'(POS_NUM_W / 2);
            end
            DIV_OUT: begin
                // add half the divisor for round to nearest
                div_num   = DIV_NUM_W'(vacc_reg) + DIV_NUM_W'(den_reg >> 1);
                div_den   = den_reg;
                div_steps = DIV_CNT_W'(DIV_NUM_W / 2);
            end
            default: ;
        endcase
    end

    assign div_start = cmd.div_start;

    bir_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .steps   (div_steps),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap_x) begin
            if (edge_col) begin
                ix_reg  <= sw - SIZE_W'(1);
                ixr_reg <= sw - SIZE_W'(1);
                rx_reg  <= '0;
            end else begin
                ix_reg  <= div_quo[SIZE_W-1:0];
                ixr_reg <= div_quo[SIZE_W-1:0] + SIZE_W'(1);
                rx_reg  <= div_rem[SIZE_W-1:0];
            end
        end
        if (cmd.cap_y) begin
            iy_reg  <= div_quo[SIZE_W-1:0];
            den_reg <= DEN_W'(dw1) * DEN_W'(dh1);
            if (edge_row) begin
                iyb_reg <= div_quo[SIZE_W-1:0];
                ry_reg  <= '0;
            end else begin
                iyb_reg <= div_quo[SIZE_W-1:0] + SIZE_W'(1);
                ry_reg  <= div_rem[SIZE_W-1:0];
            end
        end
    end

    // horizontal blend into hacc, vertical blend into vacc
    assign h_wt   = (cmd.mac_op == MAC_H_FIRST) ? dw1 - rx_reg : rx_reg;
    assign v_wt   = (cmd.mac_op == MAC_V_FIRST) ? dh1 - ry_reg : ry_reg;
    assign h_prod = HACC_W'(rd_data_reg) * HACC_W'(h_wt);
    assign v_prod = VACC_W'(hacc_reg) * VACC_W'(v_wt);

    always_ff @(posedge aclk) begin
        case (cmd.mac_op)
            MAC_H_FIRST: hacc_reg <= h_prod;
            MAC_H_ADD:   hacc_reg <= hacc_reg + h_prod;
            MAC_V_FIRST: vacc_reg <= v_prod;
            MAC_V_ADD:   vacc_reg <= vacc_reg + v_prod;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (st.bad) begin
                out_sample_reg <= '0;
                out_status_reg <= 1'b1;
            end else begin
                out_sample_reg <= (|div_quo[DIV_NUM_W-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
                                                                    : div_quo[SAMPLE_W-1:0];
                out_status_reg <= 1'b0;
            end
        end
    end

    assign m_resized_sample = out_sample_reg;
    assign m_status         = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/core/bir_ctrl.sv
// sequencer for writes and resized reads, owns the output valid flag
`default_nettype none

module bir_ctrl
    import bir_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire bir_status_t st,
    output bir_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_full_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (st.in_read) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (st.bad) begin
                    state_next = ST_LOAD;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_X;
                    state_next    = ST_DIVX;
                end
            end
            ST_DIVX: begin
                cmd.div_sel = DIV_Y;
                if (!st.div_busy) begin
                    cmd.cap_x     = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (!st.div_busy) begin
                    cmd.cap_y  = 1'b1;
                    state_next = ST_RTL;
                end
            end
            ST_RTL: begin
                cmd.mem_rd = 1'b1;
                cmd.tap    = TAP_TL;
                state_next = ST_MTL;
            end
            ST_MTL: begin
                cmd.mac_op = MAC_H_FIRST;
                cmd.mem_rd = 1'b1;
                cmd.tap    = TAP_TR;
                state_next = ST_MTR;
            end
            ST_MTR: begin
                cmd.mac_op = MAC_H_ADD;
                state_next = ST_VT;
            end
            ST_VT: begin
                cmd.mac_op = MAC_V_FIRST;
                cmd.mem_rd = 1'b1;
                cmd.tap    = TAP_BL;
                state_next = ST_MBL;
            end
            ST_MBL: begin
                cmd.mac_op = MAC_H_FIRST;
                cmd.mem_rd = 1'b1;
                cmd.tap    = TAP_BR;
                state_next = ST_MBR;
            end
            ST_MBR: begin
                cmd.mac_op = MAC_H_ADD;
                state_next = ST_VB;
            end
            ST_VB: begin
                cmd.mac_op = MAC_V_ADD;
                state_next = ST_DIVO;
            end
            ST_DIVO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_OUT;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (!st.div_busy) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait for the output register to drain
                if (!out_full_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_full_next = 1'b1;
        end else if (m_ready) begin
            out_full_next = 1'b0;
        end else begin
            out_full_next = out_full_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bilinear_image_resize_top.sv
// top level of the bilinear image resize block
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_mode s_channel s_xpos s_ypos s_sample
//  m_       out        m_valid / m_ready      m_resized_sample m_status
//  cfg_     in         cfg_valid / cfg_ready  cfg_index cfg_data
//
// a write transaction completes at accept; a read runs from accept
// to a loaded result through two position divides and one rounding
// divide on the shared radix-4 divider, plus frame reads and blends.
// aresetn is synchronous; the frame store is not cleared and needs no sweep.
// a result waits in the output register while m_ready is low; the next
// transaction is taken meanwhile and stalls only when its own result is due.
`default_nettype none

module bilinear_image_resize_top
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [CH_W-1:0]      s_channel,
    input  wire logic [COORD_W-1:0]   s_xpos,
    input  wire logic [COORD_W-1:0]   s_ypos,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [SAMPLE_W-1:0]       m_resized_sample,
    output logic                      m_status,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    bir_cmd_t    cmd;
    bir_status_t st;

    assign cfg_ready = 1'b1;

    bir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    bir_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_mode           (s_mode),
        .s_channel        (s_channel),
        .s_xpos           (s_xpos),
        .s_ypos           (s_ypos),
        .s_sample         (s_sample),
        .m_resized_sample (m_resized_sample),
        .m_status         (m_status),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule

`default_nettype wire
